// ===== hw/rtl/ttd_pkg.sv =====
// Shared types and constants of the touch tap event decoder.
// Used by ttd_scale and touch_tap_event_decoder; depends on nothing else.
`timescale 1ns / 1ps

package ttd_pkg;

	// Event types and codes
	localparam logic [15:0] EV_SYN         = 16'h0000;
	localparam logic [15:0] EV_KEY         = 16'h0001;
	localparam logic [15:0] EV_ABS         = 16'h0003;
	localparam logic [15:0] SYN_FRAME      = 16'h0000;
	localparam logic [15:0] ABS_X          = 16'h0000;
	localparam logic [15:0] ABS_Y          = 16'h0001;
	localparam logic [15:0] ABS_MT_POS_X   = 16'h0035;
	localparam logic [15:0] ABS_MT_POS_Y   = 16'h0036;
	localparam logic [15:0] ABS_MT_TRACK   = 16'h0039;
	localparam logic [15:0] KEY_CONTACT    = 16'h014A;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MIN_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MIN_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX_Y   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 3'd6;

	// Register reset values
	localparam logic [15:0] RST_VIEW_WIDTH  = 16'd1024;
	localparam logic [15:0] RST_VIEW_HEIGHT = 16'd768;
	localparam logic [31:0] RST_RAW_MIN     = 32'd0;
	localparam logic [31:0] RST_RAW_MAX     = 32'd4095;
	localparam logic [2:0]  RST_ORIENTATION = 3'd0;

	// Raw position after reset and after a tap
	localparam logic [31:0] RAW_NONE = 32'hFFFF_FFFF;

	// Orientation bits
	localparam int unsigned ORI_SWAP     = 0;
	localparam int unsigned ORI_MIRROR_H = 1;
	localparam int unsigned ORI_MIRROR_V = 2;

	// Serial scaler: one multiplier bit per step, one quotient bit per step
	localparam int unsigned VIEW_W    = 16;
	localparam int unsigned COORD_W   = 32;
	localparam int unsigned PROD_W    = COORD_W + VIEW_W;
	localparam int unsigned MUL_STEPS = VIEW_W;
	localparam int unsigned DIV_STEPS = PROD_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	// One axis to be scaled
	typedef struct packed {
		logic [COORD_W-1:0] coord;
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
		logic [VIEW_W-1:0]  view;
	} scale_req_t;

	// Scaler status toward the top level
	typedef struct packed {
		logic               busy;
		logic [COORD_W-1:0] result;
	} scale_rsp_t;

endpackage

// ===== hw/rtl/touch_tap_event_decoder.sv =====
// Touch tap event decoder, top level. Depends on ttd_pkg and ttd_scale.
// An event that yields no tap does not stall the input, and the next one is
// accepted in the following cycle. A tap is written to the output once both
// scalers have finished (without the scaling steps when both axis ranges are
// empty), later only while an earlier tap still waits in the output register;
// the input stalls until then. Reset is asynchronous, active low.
`timescale 1ns / 1ps

module touch_tap_event_decoder (
	input  logic                               clk,
	input  logic                               arst_n,

	// Configuration writes
	input  logic                               cfg_we,
	input  logic [ttd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                        cfg_wdata,

	// Input event channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [15:0]                        event_type,
	input  logic [15:0]                        event_code,
	input  logic signed [31:0]                 event_value,

	// Tap output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [31:0]                 tap_x,
	output logic signed [31:0]                 tap_y
);

	typedef enum logic {
		T_IDLE,
		T_CALC
	} state_t;

	// Configuration registers.
	logic [15:0] view_w_q;
	logic [15:0] view_h_q;
	logic [31:0] min_x_q;
	logic [31:0] max_x_q;
	logic [31:0] min_y_q;
	logic [31:0] max_y_q;
	logic [2:0]  orient_q;

	// Touch tracking state.
	logic [31:0] raw_x_q;
	logic [31:0] raw_y_q;
	logic        contact_q;
	logic        lift_q;

	state_t      state_q;
	logic        out_valid_q;
	logic [31:0] tap_x_q;
	logic [31:0] tap_y_q;

	logic                accept;
	logic                is_abs;
	logic                is_touch_key;
	logic                is_report;
	logic                code_x;
	logic                code_y;
	logic                code_track;
	logic                tap;
	logic                swap;
	logic                out_free;
	logic                capture;
	logic                start;
	ttd_pkg::scale_req_t req_x;
	ttd_pkg::scale_req_t req_y;
	ttd_pkg::scale_rsp_t rsp_x;
	ttd_pkg::scale_rsp_t rsp_y;
	logic [31:0]         span_x;
	logic [31:0]         span_y;

	// A new event is taken only while no tap is being scaled; the output
	// register lets events flow while an earlier tap waits to be taken.
	assign in_stall  = (state_q != T_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign tap_x     = tap_x_q;
	assign tap_y     = tap_y_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		is_abs       = (event_type == ttd_pkg::EV_ABS);
		is_touch_key = (event_type == ttd_pkg::EV_KEY) && (event_code == ttd_pkg::KEY_CONTACT);
		is_report    = (event_type == ttd_pkg::EV_SYN) && (event_code == ttd_pkg::SYN_FRAME);
		code_x       = (event_code == ttd_pkg::ABS_X) || (event_code == ttd_pkg::ABS_MT_POS_X);
		code_y       = (event_code == ttd_pkg::ABS_Y) || (event_code == ttd_pkg::ABS_MT_POS_Y);
		code_track   = (event_code == ttd_pkg::ABS_MT_TRACK);
		// A tap needs a contact, a lift and both coordinates seen (non-negative).
		tap          = is_report && lift_q && contact_q && !raw_x_q[31] && !raw_y_q[31];
		start        = accept && tap;
		swap         = orient_q[ttd_pkg::ORI_SWAP];
		// Both axes are done and the output register has room.
		capture      = (state_q == T_CALC) && !rsp_x.busy && !rsp_y.busy && out_free;

		// Swapping exchanges the raw point and the raw ranges, not the views.
		req_x.coord  = swap ? raw_y_q : raw_x_q;
		req_x.lo     = swap ? min_y_q : min_x_q;
		req_x.hi     = swap ? max_y_q : max_x_q;
		req_x.view   = view_w_q;
		req_y.coord  = swap ? raw_x_q : raw_y_q;
		req_y.lo     = swap ? min_x_q : min_y_q;
		req_y.hi     = swap ? max_x_q : max_y_q;
		req_y.view   = view_h_q;

		// Mirroring reflects about view-1, wrapped to 32 bits.
		span_x       = 32'(view_w_q) - 32'd1;
		span_y       = 32'(view_h_q) - 32'd1;
	end

	ttd_scale u_scale_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req_x),
		.rsp    (rsp_x)
	);

	ttd_scale u_scale_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req_y),
		.rsp    (rsp_y)
	);

	// Configuration writes; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_w_q <= ttd_pkg::RST_VIEW_WIDTH;
			view_h_q <= ttd_pkg::RST_VIEW_HEIGHT;
			min_x_q  <= ttd_pkg::RST_RAW_MIN;
			max_x_q  <= ttd_pkg::RST_RAW_MAX;
			min_y_q  <= ttd_pkg::RST_RAW_MIN;
			max_y_q  <= ttd_pkg::RST_RAW_MAX;
			orient_q <= ttd_pkg::RST_ORIENTATION;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ttd_pkg::REG_VIEW_WIDTH:  view_w_q <= cfg_wdata[15:0];
				ttd_pkg::REG_VIEW_HEIGHT: view_h_q <= cfg_wdata[15:0];
				ttd_pkg::REG_RAW_MIN_X:   min_x_q  <= cfg_wdata;
				ttd_pkg::REG_RAW_MAX_X:   max_x_q  <= cfg_wdata;
				ttd_pkg::REG_RAW_MIN_Y:   min_y_q  <= cfg_wdata;
				ttd_pkg::REG_RAW_MAX_Y:   max_y_q  <= cfg_wdata;
				ttd_pkg::REG_ORIENTATION: orient_q <= cfg_wdata[2:0];
				default: begin
				end
			endcase
		end
	end

	// Event handling, tap control and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
			raw_x_q     <= ttd_pkg::RAW_NONE;
			raw_y_q     <= ttd_pkg::RAW_NONE;
			contact_q   <= 1'b0;
			lift_q      <= 1'b0;
		end else begin
			// A new tap may replace one that leaves in this same cycle.
			if (capture) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						if (is_abs) begin
							if (code_x) begin
								raw_x_q   <= event_value;
								contact_q <= 1'b1;
							end else if (code_y) begin
								raw_y_q   <= event_value;
								contact_q <= 1'b1;
							end else if (code_track) begin
								// A negative tracking id marks the finger leaving.
								if (event_value[31]) begin
									lift_q <= 1'b1;
								end else begin
									contact_q <= 1'b1;
								end
							end
						end else if (is_touch_key) begin
							if (event_value == '0) begin
								lift_q <= 1'b1;
							end else begin
								contact_q <= 1'b1;
							end
						end else if (is_report) begin
							if (tap) begin
								// The scalers latched the raw point this cycle.
								raw_x_q   <= ttd_pkg::RAW_NONE;
								raw_y_q   <= ttd_pkg::RAW_NONE;
								contact_q <= 1'b0;
								lift_q    <= 1'b0;
								state_q   <= T_CALC;
							end else begin
								lift_q <= 1'b0;
							end
						end
					end
				end
				T_CALC: begin
					// Wait for both axes, then for room in the output register.
					if (capture) begin
						tap_x_q <= orient_q[ttd_pkg::ORI_MIRROR_H] ?
						           span_x - rsp_x.result : rsp_x.result;
						tap_y_q <= orient_q[ttd_pkg::ORI_MIRROR_V] ?
						           span_y - rsp_y.result : rsp_y.result;
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/ttd_scale.sv =====
// Serial axis scaler: (coord-lo)*(view-1)/(hi-lo), truncated toward zero.
// Depends on ttd_pkg for widths, step counts and the request/response structs.
`timescale 1ns / 1ps

module ttd_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ttd_pkg::scale_req_t req,
	output ttd_pkg::scale_rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV
	} state_t;

	state_t                          state_q;
	logic [ttd_pkg::CNT_W-1:0]       cnt_q;
	logic [ttd_pkg::COORD_W-1:0]     magd_q;
	logic [ttd_pkg::VIEW_W-1:0]      magv_q;
	logic                            neg_q;
	logic [ttd_pkg::COORD_W-1:0]     div_q;
	logic [ttd_pkg::PROD_W-1:0]      acc_q;
	logic [ttd_pkg::COORD_W:0]       rem_q;
	logic [ttd_pkg::COORD_W-1:0]     res_q;

	logic                            degenerate;
	logic [ttd_pkg::COORD_W:0]       diff;
	logic [ttd_pkg::COORD_W:0]       diff_neg;
	logic [ttd_pkg::COORD_W-1:0]     range;
	logic                            view_zero;
	logic [ttd_pkg::COORD_W:0]       shifted;
	logic                            ge;
	logic [ttd_pkg::PROD_W-1:0]      quo_next;
	logic [ttd_pkg::COORD_W-1:0]     quo_low;

	always_comb begin
		degenerate = $signed(req.hi) <= $signed(req.lo);
		diff       = {req.coord[ttd_pkg::COORD_W-1], req.coord}
		           - {req.lo[ttd_pkg::COORD_W-1], req.lo};
		diff_neg   = -diff;
		range      = req.hi - req.lo;
		view_zero  = (req.view == '0);
		shifted    = {rem_q[ttd_pkg::COORD_W-1:0], acc_q[ttd_pkg::PROD_W-1]};
		ge         = shifted >= {1'b0, div_q};
		quo_next   = {acc_q[ttd_pkg::PROD_W-2:0], ge};
		quo_low    = quo_next[ttd_pkg::COORD_W-1:0];
	end

	assign rsp = {(state_q != S_IDLE), res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (degenerate) begin
							// Empty or inverted range: the raw value goes out as is.
							res_q <= req.coord;
						end else begin
							magd_q  <= diff[ttd_pkg::COORD_W] ?
							           diff_neg[ttd_pkg::COORD_W-1:0] :
							           diff[ttd_pkg::COORD_W-1:0];
							magv_q  <= view_zero ? ttd_pkg::VIEW_W'(1) :
							           req.view - ttd_pkg::VIEW_W'(1);
							neg_q   <= diff[ttd_pkg::COORD_W] ^ view_zero;
							div_q   <= range;
							acc_q   <= '0;
							cnt_q   <= '0;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					// Multiplier bits most significant first.
					acc_q  <= {acc_q[ttd_pkg::PROD_W-2:0], 1'b0}
					        + (magv_q[ttd_pkg::VIEW_W-1] ?
					           {{ttd_pkg::VIEW_W{1'b0}}, magd_q} : '0);
					magv_q <= {magv_q[ttd_pkg::VIEW_W-2:0], 1'b0};
					if (cnt_q == ttd_pkg::CNT_W'(ttd_pkg::MUL_STEPS - 1)) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					// Restoring division, one quotient bit per cycle.
					rem_q <= ge ? shifted - {1'b0, div_q} : shifted;
					acc_q <= quo_next;
					if (cnt_q == ttd_pkg::CNT_W'(ttd_pkg::DIV_STEPS - 1)) begin
						res_q   <= neg_q ? -quo_low : quo_low;
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== bench/touch_tap_event_decoder_tb.sv =====
// Self-checking testbench for touch_tap_event_decoder: directed table, then random gestures.
// Depends on ttd_pkg and the decoder RTL; the expected taps come from a predictor in this file.
`timescale 1ns / 1ps

module touch_tap_event_decoder_tb;

	// One input event as it crosses the event channel.
	typedef struct packed {
		logic [15:0] etype;
		logic [15:0] ecode;
		logic [31:0] evalue;
	} touch_event_t;

	// One tap as it crosses the output channel.
	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} tap_t;

	// A directed row carries a typed tap only where the value is obvious.
	typedef struct packed {
		touch_event_t ev;
		logic         typed;
		tap_t         want;
	} directed_row_t;

	// Receiver stall patterns.
	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PERIODIC, RX_BUSY} rx_mode_t;

	localparam int DIRECTED_ROWS = 24;
	localparam int PHASES        = 8;     // one per orientation value
	localparam int PHASE_ITEMS   = 98;    // handled events per phase, noise excluded
	localparam int SETTLE_CYCLES = 70;    // outlasts the slowest tap
	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int QUIET_LIMIT   = 4000;  // watchdog: cycles without any transfer

	// The table runs on the reset settings: 1024 x 768 screen, raw range 0..4095.
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		// A report with nothing seen gives no tap.
		'{'{ttd_pkg::EV_SYN, ttd_pkg::SYN_FRAME, 32'h0000_0000}, 1'b0, '{32'd0, 32'd0}},
		// Lowest corner through the single-touch codes and the touch key.
		'{'{ttd_pkg::EV_ABS, ttd_pkg::ABS_X, 32'h0000_0000}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_ABS, ttd_pkg::ABS_Y, 32'h0000_0000}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_KEY, ttd_pkg::KEY_CONTACT, 32'h0000_0001}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_KEY, ttd_pkg::KEY_CONTACT, 32'h0000_0000}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_SYN, ttd_pkg::SYN_FRAME, 32'h0000_0000}, 1'b1, '{32'd0, 32'd0}},
		// Highest corner through the multi-touch codes and the tracking id.
		'{'{ttd_pkg::EV_ABS, ttd_pkg::ABS_MT_POS_X, 32'd4095}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_ABS, ttd_pkg::ABS_MT_POS_Y, 32'd4095}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_ABS, ttd_pkg::ABS_MT_TRACK, 32'h7FFF_FFFF}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_ABS, ttd_pkg::ABS_MT_TRACK, 32'h8000_0000}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_SYN, ttd_pkg::SYN_FRAME, 32'h0000_0000}, 1'b1, '{32'd1023, 32'd767}},
		// A lift alone is dropped by the report that follows it.
		'{'{ttd_pkg::EV_ABS, ttd_pkg::ABS_MT_TRACK, 32'hFFFF_FFFF}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_SYN, ttd_pkg::SYN_FRAME, 32'h0000_0000}, 1'b0, '{32'd0, 32'd0}},
		// A negative coordinate blocks the tap but the positions are kept.
		'{'{ttd_pkg::EV_ABS, ttd_pkg::ABS_X, 32'h7FFF_FFFF}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_ABS, ttd_pkg::ABS_Y, 32'h8000_0000}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_KEY, ttd_pkg::KEY_CONTACT, 32'h0000_0000}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_SYN, ttd_pkg::SYN_FRAME, 32'h0000_0000}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_ABS, ttd_pkg::ABS_Y, 32'd2048}, 1'b0, '{32'd0, 32'd0}},
		// Events the block must ignore, at the field extremes.
		'{'{ttd_pkg::EV_SYN, 16'hFFFF, 32'h0000_0000}, 1'b0, '{32'd0, 32'd0}},
		'{'{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_KEY, 16'h0000, 32'h0000_0000}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_ABS, 16'h002F, 32'h0000_0005}, 1'b0, '{32'd0, 32'd0}},
		// Lift again; the old X beyond the raw range is scaled as it stands.
		'{'{ttd_pkg::EV_KEY, ttd_pkg::KEY_CONTACT, 32'h0000_0000}, 1'b0, '{32'd0, 32'd0}},
		'{'{ttd_pkg::EV_SYN, ttd_pkg::SYN_FRAME, 32'h0000_0000}, 1'b0, '{32'd0, 32'd0}}
	};

	// Clock, reset and the block's inputs, all known from time zero.
	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_we      = 1'b0;
	logic [ttd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]        cfg_wdata   = '0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [15:0]        event_type  = '0;
	logic [15:0]        event_code  = '0;
	logic signed [31:0] event_value = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic signed [31:0] tap_x;
	logic signed [31:0] tap_y;

	// Shadow copy of the registers, kept in step with every write.
	logic [15:0] view_w = ttd_pkg::RST_VIEW_WIDTH;
	logic [15:0] view_h = ttd_pkg::RST_VIEW_HEIGHT;
	logic [31:0] min_x  = ttd_pkg::RST_RAW_MIN;
	logic [31:0] max_x  = ttd_pkg::RST_RAW_MAX;
	logic [31:0] min_y  = ttd_pkg::RST_RAW_MIN;
	logic [31:0] max_y  = ttd_pkg::RST_RAW_MAX;
	logic [2:0]  orient = ttd_pkg::RST_ORIENTATION;

	// Predicted gesture state of the decoder.
	logic [31:0] raw_x    = ttd_pkg::RAW_NONE;
	logic [31:0] raw_y    = ttd_pkg::RAW_NONE;
	logic        touching = 1'b0;
	logic        lifted   = 1'b0;

	tap_t taps_due[$];        // taps predicted and not yet seen on the output

	int fail_count    = 0;
	int taps_checked  = 0;
	int events_sent   = 0;
	int gestures_sent = 0;
	int burst_left    = 0;
	int quiet_cycles  = 0;
	int rx_hold_asked = 0;    // written by the stimulus only
	int rx_hold_taken = 0;    // written by the receiver only
	int rx_hold_left  = 0;
	int rx_mode_left  = 0;
	int rx_tick       = 0;
	rx_mode_t rx_mode = RX_FREE;

	touch_tap_event_decoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.event_type  (event_type),
		.event_code  (event_code),
		.event_value (event_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tap_x       (tap_x),
		.tap_y       (tap_y)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Scale one axis: (coord - lo) * (view - 1) / (hi - lo) in 64-bit signed
	// arithmetic, truncated toward zero and wrapped to 32 bits. An empty or
	// inverted range passes the raw coordinate through.
	function automatic logic [31:0] scale_coord(input logic signed [31:0] c,
			input logic signed [31:0] lo, input logic signed [31:0] hi,
			input logic [15:0] view);
		longint span_px;
		longint prod;
		if (hi <= lo)
			return c;
		span_px = longint'({48'd0, view}) - 64'sd1;
		prod = (longint'(c) - longint'(lo)) * span_px;
		prod = prod / (longint'(hi) - longint'(lo));
		return prod[31:0];
	endfunction

	// Advance the predicted gesture state by one event. Returns 1 when the
	// event completes a tap, with the screen point in px and py.
	function automatic bit track_touch(input touch_event_t ev,
			output logic [31:0] px, output logic [31:0] py);
		logic signed [31:0] cx, cy, lox, hix, loy, hiy, t;
		px = '0;
		py = '0;
		if (ev.etype == ttd_pkg::EV_ABS) begin
			if (ev.ecode == ttd_pkg::ABS_MT_POS_X || ev.ecode == ttd_pkg::ABS_X) begin
				raw_x = ev.evalue;
				touching = 1'b1;
			end else if (ev.ecode == ttd_pkg::ABS_MT_POS_Y || ev.ecode == ttd_pkg::ABS_Y) begin
				raw_y = ev.evalue;
				touching = 1'b1;
			end else if (ev.ecode == ttd_pkg::ABS_MT_TRACK) begin
				// A negative tracking id means the finger went away.
				if (ev.evalue[31])
					lifted = 1'b1;
				else
					touching = 1'b1;
			end
		end else if (ev.etype == ttd_pkg::EV_KEY && ev.ecode == ttd_pkg::KEY_CONTACT) begin
			if (ev.evalue == 32'd0)
				lifted = 1'b1;
			else
				touching = 1'b1;
		end else if (ev.etype == ttd_pkg::EV_SYN && ev.ecode == ttd_pkg::SYN_FRAME) begin
			if (lifted && touching && !raw_x[31] && !raw_y[31]) begin
				cx = raw_x;
				cy = raw_y;
				lox = min_x;
				hix = max_x;
				loy = min_y;
				hiy = max_y;
				// Swapping exchanges the raw point and the raw ranges, never the view.
				if (orient[ttd_pkg::ORI_SWAP]) begin
					t = cx;  cx = cy;   cy = t;
					t = lox; lox = loy; loy = t;
					t = hix; hix = hiy; hiy = t;
				end
				px = scale_coord(cx, lox, hix, view_w);
				py = scale_coord(cy, loy, hiy, view_h);
				if (orient[ttd_pkg::ORI_MIRROR_H])
					px = ({16'd0, view_w} - 32'd1) - px;
				if (orient[ttd_pkg::ORI_MIRROR_V])
					py = ({16'd0, view_h} - 32'd1) - py;
				raw_x = ttd_pkg::RAW_NONE;
				raw_y = ttd_pkg::RAW_NONE;
				touching = 1'b0;
				lifted = 1'b0;
				return 1'b1;
			end
			// A report without a tap forgets only the lift.
			lifted = 1'b0;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		if (fail_count <= 200)
			$display("MISMATCH %0t ns, tap %0d: %s is 0x%08h, expected 0x%08h",
				$time, taps_checked, what, got, want);
	endtask

	// Write one register and keep the shadow copy in step. The caller lowers
	// the write enable after the last write.
	task automatic cfg_write(input logic [ttd_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		case (idx)
			ttd_pkg::REG_VIEW_WIDTH:  view_w = data[15:0];
			ttd_pkg::REG_VIEW_HEIGHT: view_h = data[15:0];
			ttd_pkg::REG_RAW_MIN_X:   min_x = data;
			ttd_pkg::REG_RAW_MAX_X:   max_x = data;
			ttd_pkg::REG_RAW_MIN_Y:   min_y = data;
			ttd_pkg::REG_RAW_MAX_Y:   max_y = data;
			ttd_pkg::REG_ORIENTATION: orient = data[2:0];
			default: ;
		endcase
	endtask

	// Offer one event. The sender works in bursts with random gaps between
	// them; the event is held until the decoder takes the transfer.
	task automatic offer_event(input touch_event_t ev, input logic typed, input tap_t want);
		int gap;
		logic [31:0] px, py;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		in_valid = 1'b1;
		event_type = ev.etype;
		event_code = ev.ecode;
		event_value = ev.evalue;
		do @(posedge clk); while (in_stall);
		events_sent++;
		burst_left--;
		if (track_touch(ev, px, py)) begin
			if (typed)
				taps_due.push_back(want);
			else
				taps_due.push_back('{px, py});
		end
	endtask

	// Stop offering, wait until every predicted tap has been taken and, when
	// registers are about to change, let the decoder run dry.
	task automatic drain_taps(input bit settle);
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		while (taps_due.size() != 0)
			@(posedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic touch_event_t mk_ev(input logic [15:0] etype,
			input logic [15:0] ecode, input logic [31:0] evalue);
		return '{etype, ecode, evalue};
	endfunction

	// Raw coordinate: mostly inside the programmed range, with the range
	// ends, zero, the largest positive value and fully random values mixed in.
	function automatic logic [31:0] pick_coord(input logic [31:0] lo, input logic [31:0] hi);
		longint span;
		longint offs;
		case ($urandom_range(0, 11))
			0: return 32'd0;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			3: return lo;
			4: return hi;
			default: begin
				span = longint'($signed(hi)) - longint'($signed(lo)) + 64'sd1;
				if (span <= 1)
					return $urandom_range(0, 4095);
				offs = longint'({$urandom, $urandom} >> 1) % span;
				return lo + offs[31:0];
			end
		endcase
	endfunction

	// Finger-down event: either the touch key pressed or a live tracking id.
	function automatic touch_event_t contact_ev();
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(0, 1))
			return mk_ev(ttd_pkg::EV_KEY, ttd_pkg::KEY_CONTACT, (v == 32'd0) ? 32'd1 : v);
		return mk_ev(ttd_pkg::EV_ABS, ttd_pkg::ABS_MT_TRACK, {1'b0, v[30:0]});
	endfunction

	// One random gesture. Most are complete taps with random content; the
	// rest are broken gestures, bare reports and noise. Returns how many
	// events counted toward the phase, noise excluded.
	task automatic send_gesture(output int counted);
		touch_event_t seq[$];
		touch_event_t xev, yev, lift_ev;
		logic [31:0] v;
		int kind;
		int i;
		bit noise;
		noise = 1'b0;
		kind = $urandom_range(0, 19);
		v = $urandom;
		xev = mk_ev(ttd_pkg::EV_ABS,
			$urandom_range(0, 1) ? ttd_pkg::ABS_X : ttd_pkg::ABS_MT_POS_X,
			pick_coord(min_x, max_x));
		yev = mk_ev(ttd_pkg::EV_ABS,
			$urandom_range(0, 1) ? ttd_pkg::ABS_Y : ttd_pkg::ABS_MT_POS_Y,
			pick_coord(min_y, max_y));
		lift_ev = $urandom_range(0, 1) ? mk_ev(ttd_pkg::EV_KEY, ttd_pkg::KEY_CONTACT, 32'd0)
			: mk_ev(ttd_pkg::EV_ABS, ttd_pkg::ABS_MT_TRACK, v | 32'h8000_0000);
		if (kind < 14) begin
			if ($urandom_range(0, 3) == 0)
				seq.push_back(lift_ev);
			if ($urandom_range(0, 1))
				seq.push_back(contact_ev());
			if ($urandom_range(0, 1)) begin
				seq.push_back(xev);
				seq.push_back(yev);
			end else begin
				seq.push_back(yev);
				seq.push_back(xev);
			end
			if ($urandom_range(0, 3) == 0)
				seq.push_back(mk_ev(ttd_pkg::EV_ABS, ttd_pkg::ABS_MT_POS_X,
					pick_coord(min_x, max_x)));
			seq.push_back(lift_ev);
			seq.push_back(mk_ev(ttd_pkg::EV_SYN, ttd_pkg::SYN_FRAME, $urandom));
		end else if (kind < 16) begin
			// Broken: positions without a lift, or a lift without positions.
			if ($urandom_range(0, 1)) begin
				seq.push_back(xev);
				seq.push_back(yev);
			end else begin
				seq.push_back(contact_ev());
				seq.push_back(lift_ev);
			end
			seq.push_back(mk_ev(ttd_pkg::EV_SYN, ttd_pkg::SYN_FRAME, 32'd0));
		end else if (kind < 18) begin
			noise = 1'b1;
			repeat ($urandom_range(1, 3)) begin
				v = $urandom;
				case ($urandom_range(0, 3))
					0: seq.push_back(mk_ev(v[15:0], v[31:16], $urandom));
					1: seq.push_back(mk_ev(ttd_pkg::EV_SYN, v[15:0] | 16'h0001, $urandom));
					2: seq.push_back(mk_ev(ttd_pkg::EV_KEY, v[15:0], $urandom));
					default: seq.push_back(mk_ev(ttd_pkg::EV_ABS, v[15:0], $urandom));
				endcase
			end
		end else begin
			repeat ($urandom_range(1, 2))
				seq.push_back(mk_ev(ttd_pkg::EV_SYN, ttd_pkg::SYN_FRAME, $urandom));
		end
		for (i = 0; i < seq.size(); i++)
			offer_event(seq[i], 1'b0, '{32'd0, 32'd0});
		gestures_sent++;
		counted = noise ? 0 : seq.size();
	endtask

	// Register setting for one phase. Phase p uses orientation p, so all
	// eight orientations are seen. The first three phases take the extremes:
	// widest view with the full raw range, a one-pixel view, and empty or
	// inverted ranges. Unused upper bits of the narrow registers carry noise.
	task automatic load_setting(input int p);
		logic [15:0] vw, vh;
		logic [31:0] lx, hx, ly, hy, junk;
		junk = $urandom;
		case (p)
			0: begin
				vw = 16'hFFFF;       vh = 16'hFFFF;
				lx = 32'h8000_0000;  hx = 32'h7FFF_FFFF;
				ly = 32'h8000_0000;  hy = 32'h7FFF_FFFF;
			end
			1: begin
				vw = 16'd1;          vh = 16'd1;
				lx = 32'd0;          hx = 32'd100;
				ly = 32'd0;          hy = 32'd100;
			end
			2: begin
				vw = 16'($urandom_range(1, 65535));
				vh = 16'($urandom_range(1, 65535));
				lx = 32'd500;        hx = 32'd500;
				ly = 32'd1000;       hy = 32'd10;
			end
			default: begin
				vw = 16'($urandom_range(1, 4000));
				vh = 16'($urandom_range(1, 4000));
				lx = $urandom_range(0, 10000) - 5000;
				hx = lx + $urandom_range(1, 100000);
				ly = $urandom_range(0, 10000) - 5000;
				hy = ($urandom_range(0, 3) == 0) ? ly : ly + $urandom_range(1, 100000);
			end
		endcase
		cfg_write(ttd_pkg::REG_VIEW_WIDTH, {junk[31:16], vw});
		cfg_write(ttd_pkg::REG_VIEW_HEIGHT, {junk[15:0], vh});
		cfg_write(ttd_pkg::REG_RAW_MIN_X, lx);
		cfg_write(ttd_pkg::REG_RAW_MAX_X, hx);
		cfg_write(ttd_pkg::REG_RAW_MIN_Y, ly);
		cfg_write(ttd_pkg::REG_RAW_MAX_Y, hy);
		cfg_write(ttd_pkg::REG_ORIENTATION, {junk[31:3], p[2:0]});
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Receiver. Stalls follow a pattern that changes every so often: free
	// running, coin toss, a fixed period, or mostly stalled. When the stimulus
	// asks for it, the receiver holds off for a long stretch so that taps back
	// up into the decoder and its input stalls.
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			out_stall = 1'b1;
			rx_hold_left--;
		end else if (rx_hold_asked != rx_hold_taken) begin
			rx_hold_taken++;
			rx_hold_left = HOLD_CYCLES - 1;
			out_stall = 1'b1;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(10, 200);
			end
			rx_mode_left--;
			rx_tick++;
			case (rx_mode)
				RX_FREE:     out_stall = 1'b0;
				RX_COIN:     out_stall = 1'($urandom_range(0, 1));
				RX_PERIODIC: out_stall = (rx_tick % 4) == 0;
				RX_BUSY:     out_stall = $urandom_range(0, 3) != 0;
				default:     out_stall = 1'b0;
			endcase
		end
	end

	// Check every tap transfer, field by field, against the oldest prediction.
	always @(posedge clk) begin
		tap_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (taps_due.size() == 0) begin
				report_mismatch("unexpected tap, tap_x", tap_x, 32'd0);
			end else begin
				want = taps_due.pop_front();
				if (tap_x !== want.x)
					report_mismatch("tap_x", tap_x, want.x);
				if (tap_y !== want.y)
					report_mismatch("tap_y", tap_y, want.y);
				taps_checked++;
			end
		end
	end

	// Watchdog: the run is hung if neither channel completes a transfer for
	// far longer than the long hold-off plus the slowest tap.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d taps still pending",
					QUIET_LIMIT, taps_due.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Stimulus: reset, the directed table on the reset settings, then one
	// random phase per register setting.
	initial begin
		int i;
		int phase;
		int done;
		int n;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < DIRECTED_ROWS; i++)
			offer_event(DIRECTED[i].ev, DIRECTED[i].typed, DIRECTED[i].want);

		for (phase = 0; phase < PHASES; phase++) begin
			drain_taps(1'b1);
			load_setting(phase);
			// Hold the receiver off while the sender keeps pushing.
			if (phase == 0 || phase == 5)
				rx_hold_asked++;
			done = 0;
			while (done < PHASE_ITEMS) begin
				send_gesture(n);
				done += n;
				if ($urandom_range(0, 29) == 0)
					drain_taps(1'b0);
			end
		end
		drain_taps(1'b1);

		$display("Covered %0d events (%0d directed, %0d random gestures) over %0d settings",
			events_sent, DIRECTED_ROWS, gestures_sent, PHASES + 1);
		$display("Checked %0d taps; receiver held off %0d times for %0d cycles",
			taps_checked, rx_hold_taken, HOLD_CYCLES);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
